@@ hdl/u16u8_pkg.sv @@
// shared types, constants and helper functions for the utf-16 to utf-8 transcoder
package u16u8_pkg;

    localparam logic [15:0] BOM_SWAPPED = 16'hFFFE;
    localparam logic [15:0] BOM_NATIVE  = 16'hFEFF;

    localparam int CP_W = 21;

    typedef enum logic [1:0] {
        BOM_DETECT       = 2'd0,
        BOM_FORCE_SWAP   = 2'd1,
        BOM_FORCE_NATIVE = 2'd2,
        BOM_UNUSED       = 2'd3
    } bom_mode_t;

    typedef enum logic {
        CFG_REPLACEMENT = 1'b0,
        CFG_BOM_MODE    = 1'b1
    } cfg_index_t;

    // one queued result: a code point to encode, or an error marker
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            err;
        logic            swap;
    } u16u8_entry_t;

    function automatic logic is_legal(input logic [31:0] v);
        logic ok;
        begin
            if (v < 32'h0000_D800)
                ok = 1'b1;
            else if (v <= 32'h0000_DFFF || v > 32'h0010_FFFF)
                ok = 1'b0;
            else
                ok = (v[15:1] != 15'h7FFF);
            return ok;
        end
    endfunction

    function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
        logic [2:0] n;
        begin
            if (cp < 21'h80)
                n = 3'd1;
            else if (cp < 21'h800)
                n = 3'd2;
            else if (cp < 21'h10000)
                n = 3'd3;
            else
                n = 3'd4;
            return n;
        end
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [2:0] n,
                                             input logic [1:0] k);
        logic [7:0] b;
        begin
            case ({n, k})
                {3'd1, 2'd0}: b = {1'b0, cp[6:0]};
                {3'd2, 2'd0}: b = {3'b110, cp[10:6]};
                {3'd2, 2'd1}: b = {2'b10, cp[5:0]};
                {3'd3, 2'd0}: b = {4'b1110, cp[15:12]};
                {3'd3, 2'd1}: b = {2'b10, cp[11:6]};
                {3'd3, 2'd2}: b = {2'b10, cp[5:0]};
                {3'd4, 2'd0}: b = {5'b11110, cp[20:18]};
                {3'd4, 2'd1}: b = {2'b10, cp[17:12]};
                {3'd4, 2'd2}: b = {2'b10, cp[11:6]};
                {3'd4, 2'd3}: b = {2'b10, cp[5:0]};
                default:      b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

@@ hdl/u16u8_front.sv @@
// front end: config registers, byte order, surrogate pairing and validity check
module u16u8_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_wdata,
    input  logic                  accept,
    input  logic [15:0]           code_unit,
    input  logic                  stream_start,
    input  logic                  stream_end,
    output logic                  push,
    output u16u8_pkg::u16u8_entry_t push_entry
);
    import u16u8_pkg::*;

    logic [31:0] repl_reg;
    bom_mode_t   mode_reg;
    logic [9:0]  held_reg, held_next;
    logic        pending_reg, pending_next;
    logic        swap_reg, swap_next;
    logic        halted_reg, halted_next;

    logic        pend_eff, halt_eff, drop, has_result, bad, repl_ok;
    logic [15:0] v;
    logic [CP_W-1:0] cp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg    <= 32'h0000_FFFD;
            mode_reg    <= BOM_DETECT;
            held_reg    <= '0;
            pending_reg <= 1'b0;
            swap_reg    <= 1'b0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index_t'(cfg_index) == CFG_REPLACEMENT)
                    repl_reg <= cfg_wdata;
                else
                    mode_reg <= bom_mode_t'(cfg_wdata[1:0]);
            end
            if (accept)
            begin
                held_reg    <= held_next;
                pending_reg <= pending_next;
                swap_reg    <= swap_next;
                halted_reg  <= halted_next;
            end
        end
    end

    assign repl_ok = is_legal(repl_reg);

    always_comb
    begin
        held_next    = held_reg;
        pending_next = pending_reg;
        swap_next    = swap_reg;
        halted_next  = halted_reg;
        drop         = 1'b0;
        pend_eff     = pending_reg;
        halt_eff     = halted_reg;
        bad          = 1'b0;
        has_result   = 1'b0;
        cp           = '0;

        if (stream_start)
        begin
            pend_eff    = 1'b0;
            halt_eff    = 1'b0;
            held_next   = '0;
            pending_next = 1'b0;
            halted_next = 1'b0;
            unique case (mode_reg)
                BOM_FORCE_SWAP:   swap_next = 1'b1;
                BOM_FORCE_NATIVE: swap_next = 1'b0;
                default:
                begin
                    swap_next = (code_unit == BOM_SWAPPED);
                    drop = (code_unit == BOM_SWAPPED) || (code_unit == BOM_NATIVE);
                end
            endcase
        end

        v = swap_next ? {code_unit[7:0], code_unit[15:8]} : code_unit;

        if (!drop && !halt_eff)
        begin
            has_result = 1'b1;
            if (pend_eff)
            begin
                pending_next = 1'b0;
                if (v[15:10] != 6'b110111)
                    bad = 1'b1;
                else
                    cp = 21'h10000 + {1'b0, held_next, v[9:0]};
            end
            else if (v[15:11] == 5'b11011)
            begin
                if (v[10] || stream_end)
                    bad = 1'b1;
                else
                begin
                    // high surrogate waits for its partner
                    held_next    = v[9:0];
                    pending_next = 1'b1;
                    has_result   = 1'b0;
                end
            end
            else
                cp = {5'd0, v};

            if (!bad && !is_legal({11'd0, cp}))
                bad = 1'b1;
            if (bad)
            begin
                if (!repl_ok)
                begin
                    halted_next  = 1'b1;
                    pending_next = 1'b0;
                    held_next    = '0;
                end
                cp = repl_reg[CP_W-1:0];
            end
        end
    end

    assign push            = accept && has_result;
    assign push_entry.cp   = cp;
    assign push_entry.err  = bad && !repl_ok;
    assign push_entry.swap = swap_next;

endmodule

@@ hdl/u16u8_fifo.sv @@
// small register queue between the front and back ends
module u16u8_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  u16u8_pkg::u16u8_entry_t push_entry,
    input  logic                    pop,
    output u16u8_pkg::u16u8_entry_t head,
    output logic                    full,
    output logic                    nonempty
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    u16u8_entry_t     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == LAST_PTR) ? '0 : wr_reg + PTR_W'(1);
            if (pop)
                rd_reg <= (rd_reg == LAST_PTR) ? '0 : rd_reg + PTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign head     = slot_reg[rd_reg];
    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign nonempty = (cnt_reg != '0);

endmodule

@@ hdl/u16u8_back.sv @@
// back end: serializes each queued code point into utf-8 bytes
module u16u8_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  u16u8_pkg::u16u8_entry_t head,
    input  logic                    nonempty,
    output logic                    pop,
    output logic                    byte_valid,
    input  logic                    byte_stall,
    output logic [7:0]              out_byte,
    output logic                    last_of_run,
    output logic                    error_halt,
    output logic                    swapped_order
);
    import u16u8_pkg::*;

    u16u8_entry_t ent_reg;
    logic [2:0]   len_reg;
    logic [1:0]   idx_reg;
    logic         busy_reg;
    logic         oval_reg;
    logic [7:0]   obyte_reg;
    logic         olast_reg, oerr_reg, oswap_reg;

    logic advance, final_byte;
    logic [7:0] cur_byte;

    assign advance    = !oval_reg || !byte_stall;
    assign final_byte = ({1'b0, idx_reg} == len_reg - 3'd1);
    assign pop        = nonempty && (!busy_reg || (advance && final_byte));
    assign cur_byte   = ent_reg.err ? 8'h00 : utf8_byte(ent_reg.cp, len_reg, idx_reg);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= head;
            len_reg <= head.err ? 3'd1 : utf8_len(head.cp);
        end
        if (advance && busy_reg)
        begin
            obyte_reg <= cur_byte;
            olast_reg <= final_byte;
            oerr_reg  <= ent_reg.err;
            oswap_reg <= ent_reg.swap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            oval_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                oval_reg <= busy_reg;
            if (pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance && busy_reg)
            begin
                if (final_byte)
                    busy_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    assign byte_valid    = oval_reg;
    assign out_byte      = obyte_reg;
    assign last_of_run   = olast_reg;
    assign error_halt    = oerr_reg;
    assign swapped_order = oswap_reg;

endmodule

@@ hdl/utf16_to_utf8_transcoder_top.sv @@
// top level of the utf-16 to utf-8 transcoder
// path: a unit that gives bytes goes through a queue slot, the back end entry register
//   and the output register; throughput: one byte per cycle while byte_stall is low
//   and the queue is not empty, 1 to 4 bytes per unit; the back end serializer sets this figure
// the input side takes a unit every cycle while the result queue has room
// reset: rst_n is asynchronous, active low; clears state, queue and output valid,
//   loads replacement 0xfffd and bom detect mode
module utf16_to_utf8_transcoder_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    // code unit channel
    input  logic        unit_valid,
    output logic        unit_stall,
    input  logic [15:0] code_unit,
    input  logic        stream_start,
    input  logic        stream_end,
    // utf-8 byte channel
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        error_halt,
    output logic        swapped_order
);
    import u16u8_pkg::*;

    logic         accept;
    logic         push, pop, full, nonempty;
    u16u8_entry_t push_entry, head;

    // a unit transfers whenever the queue has a free slot; units that give
    // no bytes (marks, held high surrogates, halted stream) still transfer
    assign unit_stall = full;
    assign accept     = unit_valid && !unit_stall;

    // front: decides what each unit produces and keeps the stream state
    u16u8_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .accept       (accept),
        .code_unit    (code_unit),
        .stream_start (stream_start),
        .stream_end   (stream_end),
        .push         (push),
        .push_entry   (push_entry)
    );

    // queue of pending code points, decouples unit intake from byte output
    u16u8_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .nonempty   (nonempty)
    );

    // back: one utf-8 byte per output transfer, into a held output register
    u16u8_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .nonempty      (nonempty),
        .pop           (pop),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .error_halt    (error_halt),
        .swapped_order (swapped_order)
    );

endmodule

@@ hdl/u16u8_checker.sv @@
// port-level checks for the transcoder, bound to the top level
module u16u8_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       byte_valid,
    input logic       byte_stall,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       error_halt,
    input logic       swapped_order
);

    // an error result is a single zero byte
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && error_halt |-> last_of_run && (out_byte == 8'h00))
        else $error("error result is not a lone zero byte");

    // only multi-byte sequences have bytes after this one
    a_mid_seq: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !last_of_run |-> out_byte[7] && !error_halt)
        else $error("non-final byte is not part of a multi-byte sequence");

    // bytes of one code point follow without gaps and share the byte order
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && !last_of_run |=>
            byte_valid && (swapped_order == $past(swapped_order)))
        else $error("gap or order change inside a byte run");

    // stalled output holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=>
            byte_valid && $stable(out_byte) && $stable(last_of_run))
        else $error("stalled byte changed");

endmodule

bind utf16_to_utf8_transcoder_top u16u8_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .error_halt    (error_halt),
    .swapped_order (swapped_order)
);
